// ===== hw/rtl/oat_pkg.sv =====
// Shared types and codes for the ordered array table.
package oat_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FIDX_W   = 5;
    localparam int unsigned COUNT_W  = 6;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

    typedef enum logic [3:0] {
        CELL_HOLD = 4'b0001,
        CELL_CMP  = 4'b0010,
        CELL_INS  = 4'b0100,
        CELL_DEL  = 4'b1000
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] key;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/ordered_array_table.sv =====
// Top level of the ordered array table: request sequencer and a row of table cells.
// Results are registered at the end of the update state, which follows the compare state, and show with done high.
// A new request is taken only while idle; busy covers the compare state and the update state.
// The compare pass registers a match bit in every cell; the update pass runs the first-match
// chain along the row and shifts the entries in the same cycle.
// Reset clears the count and control; entries stay undefined until written. No output stall.
module ordered_array_table
    import oat_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [DATA_W-1:0]   value,
    input  logic [POS_W-1:0]    position,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [FIDX_W-1:0]   found_index,
    output logic [COUNT_W-1:0]  element_count
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    // Control state
    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic                done_next;

    // Request held for the duration of the item
    logic [REQ_W-1:0]    req_reg;
    logic [DATA_W-1:0]   key_reg;
    logic [POS_W-1:0]    pos_reg;

    // Result registers
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [FIDX_W-1:0]   fidx_reg;
    logic [FIDX_W-1:0]   fidx_next;
    logic [COUNT_W-1:0]  ecount_reg;
    logic [COUNT_W-1:0]  ecount_next;

    // Row wiring
    cell_cmd_t           cmd;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    count_ext;
    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY:0]   seen;
    logic [CAPACITY-1:0] first;
    logic [IDX_W-1:0]    match_idx;
    logic                found;
    logic                is_full;
    logic                bad_pos;
    logic                accept;

    assign accept    = start & ~busy;
    assign busy      = (state_reg != S_IDLE);
    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign seen[0]   = 1'b0;
    assign found     = seen[CAPACITY];
    assign is_full   = (count_reg == FULL_COUNT);
    assign bad_pos   = (pos_ext > count_ext);

    // Encode the one-hot first match into an index
    always_comb
    begin
        match_idx = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (first[k])
            begin
                match_idx = match_idx | IDX_W'(k);
            end
        end
    end

    // Sequence the item and decide what the row does
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        fidx_next   = fidx_reg;
        ecount_next = ecount_reg;
        cmd.op      = CELL_HOLD;
        cmd.key     = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // register one match bit per cell
                cmd.op     = CELL_CMP;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                status_next = ST_OK;
                fidx_next   = '0;
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (bad_pos)
                        begin
                            status_next = ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.op     = CELL_INS;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (found)
                        begin
                            cmd.op     = CELL_DEL;
                            fidx_next  = FIDX_W'(match_idx);
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (found)
                        begin
                            fidx_next = FIDX_W'(match_idx);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // meaningless request: report ok, change nothing
                        status_next = ST_OK;
                    end
                endcase
                ecount_next = COUNT_W'(count_next);
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold the request and the result; no reset needed on payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= value;
            pos_reg <= position;
        end
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        ecount_reg <= ecount_next;
    end

    // Row of cells; each passes its entry to both neighbors and the match chain to the right
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (k == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[k+1];
        end

        oat_cell #(
            .CMP_W (CMP_W),
            .INDEX (k)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_ext),
            .count      (count_ext),
            .left_data  (left_d),
            .right_data (right_d),
            .seen_in    (seen[k]),
            .data       (cell_data[k]),
            .seen_out   (seen[k+1]),
            .first      (first[k])
        );
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign found_index   = fidx_reg;
    assign element_count = ecount_reg;

endmodule

// ===== hw/rtl/oat_cell.sv =====
// One slot of the table: holds an entry, compares it and shifts with its neighbors.
module oat_cell
    import oat_pkg::*;
#(
    parameter int unsigned CMP_W = 6,
    parameter int unsigned INDEX = 0
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [CMP_W-1:0]  pos,
    input  logic [CMP_W-1:0]  count,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    input  logic              seen_in,
    output logic [DATA_W-1:0] data,
    output logic              seen_out,
    output logic              first
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_reg;
    logic              match_next;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (cmd.op)
            CELL_CMP:
            begin
                match_next = (data_reg == cmd.key) && (MY_IDX < count);
            end
            CELL_INS:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = cmd.key;
                end
                else if (MY_IDX > pos && MY_IDX <= count)
                begin
                    data_next = left_data;
                end
            end
            CELL_DEL:
            begin
                // close the gap: every slot from the first match on takes its right neighbor
                if (seen_out)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data     = data_reg;
    assign first    = match_reg & ~seen_in;
    assign seen_out = match_reg | seen_in;

endmodule
